[hdl/sha1_pkg.sv]
// ----------------------------------------------------------------------------
// sha1_pkg: shared types, constants and round functions
// Word and chain types, initial chaining values, round constants and the
// control bundles passed from the sequencer to the datapath units.
// ----------------------------------------------------------------------------
package sha1_pkg;

    localparam int unsigned WORD_BITS  = 32;
    localparam int unsigned NUM_CHAIN  = 5;
    localparam int unsigned NUM_ROUNDS = 80;
    localparam int unsigned BLK_BYTES  = 64;
    localparam int unsigned BLK_BITS   = BLK_BYTES * 8;
    localparam int unsigned LEN_BITS   = 64;

    typedef logic [WORD_BITS-1:0]                t_word;
    typedef logic [NUM_CHAIN-1:0][WORD_BITS-1:0] t_chain;
    typedef logic [6:0]                          t_round;
    typedef logic [5:0]                          t_fill;
    typedef logic [2:0]                          t_word_num;

    localparam t_chain CHAIN_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam t_word K_0 = 32'h5A827999;
    localparam t_word K_1 = 32'h6ED9EBA1;
    localparam t_word K_2 = 32'h8F1BBCDC;
    localparam t_word K_3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam t_fill      LEN_POS  = 6'd55 + 6'd1;
    localparam t_fill      LAST_POS = 6'd63;
    localparam t_round     LAST_RND = 7'd79;
    localparam t_word_num  LAST_WRD = 3'd4;

    typedef struct packed {
        logic       push;
        logic       shift;
        logic [7:0] data;
    } t_sched_ctl;

    typedef struct packed {
        logic init;
        logic load;
        logic step;
        logic add;
    } t_core_ctl;

    function automatic t_word rotl(input t_word x, input int unsigned n);
        return (x << n) | (x >> (WORD_BITS - n));
    endfunction

    function automatic t_word round_f(input t_round idx, input t_word b,
                                      input t_word c, input t_word d);
        t_word f;
        if (idx < 7'd20) begin
            f = (b & c) | (~b & d);
        end else if (idx < 7'd40) begin
            f = b ^ c ^ d;
        end else if (idx < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

    function automatic t_word round_k(input t_round idx);
        t_word k;
        if (idx < 7'd20) begin
            k = K_0;
        end else if (idx < 7'd40) begin
            k = K_1;
        end else if (idx < 7'd60) begin
            k = K_2;
        end else begin
            k = K_3;
        end
        return k;
    endfunction

endpackage

[hdl/sha1_stream_if.sv]
// ----------------------------------------------------------------------------
// sha1_stream_if: request and digest channel interfaces
// Valid/ready channels carrying message bytes in and digest words out.
// ----------------------------------------------------------------------------
interface sha1_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, output data_byte, output byte_present,
                    output end_of_message, input ready);
    modport sink (input valid, input data_byte, input byte_present,
                  input end_of_message, output ready);
endinterface

interface sha1_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        last_word;

    modport source (output valid, output digest_word, output word_number,
                    output last_word, input ready);
    modport sink (input valid, input digest_word, input word_number,
                  input last_word, output ready);
endinterface

[hdl/sha1_sched.sv]
// ----------------------------------------------------------------------------
// sha1_sched: block buffer and message schedule
// A 512-bit shift register that gathers bytes and then, during the rounds,
// shifts out one schedule word per cycle while expanding the next one.
// ----------------------------------------------------------------------------
module sha1_sched
    import sha1_pkg::*;
(
    input  logic       i_clk,
    input  t_sched_ctl i_ctl,
    output t_word      o_w
);

    logic [BLK_BITS-1:0] r_blk;
    t_word               w_new;

    // window word j sits at r_blk[511-32j -: 32]
    assign w_new = rotl(r_blk[95:64] ^ r_blk[255:224] ^ r_blk[447:416] ^ r_blk[511:480], 1);
    assign o_w   = r_blk[511:480];

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_blk <= {r_blk[BLK_BITS-9:0], i_ctl.data};
        end else if (i_ctl.shift) begin
            r_blk <= {r_blk[BLK_BITS-WORD_BITS-1:0], w_new};
        end
    end

endmodule

[hdl/sha1_core.sv]
// ----------------------------------------------------------------------------
// sha1_core: shared round unit and chaining words
// One compression round per step on the working registers, plus the
// chaining add at the end of each block.
// ----------------------------------------------------------------------------
module sha1_core
    import sha1_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_core_ctl i_ctl,
    input  t_round    i_round,
    input  t_word     i_w,
    output t_chain    o_chain
);

    t_chain r_chain;
    t_word  r_a, r_b, r_c, r_d, r_e;
    t_word  n_t;

    assign n_t = rotl(r_a, 5) + round_f(i_round, r_b, r_c, r_d) + r_e + i_w
                 + round_k(i_round);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= CHAIN_INIT;
        end else if (i_ctl.init) begin
            r_chain <= CHAIN_INIT;
        end else if (i_ctl.add) begin
            r_chain[0] <= r_chain[0] + r_a;
            r_chain[1] <= r_chain[1] + r_b;
            r_chain[2] <= r_chain[2] + r_c;
            r_chain[3] <= r_chain[3] + r_d;
            r_chain[4] <= r_chain[4] + r_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
            r_e <= r_chain[4];
        end else if (i_ctl.step) begin
            r_e <= r_d;
            r_d <= r_c;
            r_c <= rotl(r_b, 30);
            r_b <= r_a;
            r_a <= n_t;
        end
    end

    assign o_chain = r_chain;

endmodule

[hdl/sha1_stream_hasher.sv]
// ----------------------------------------------------------------------------
// sha1_stream_hasher: streaming SHA-1 digest engine
// Takes message bytes, pads on end of message and returns five digest words.
// ----------------------------------------------------------------------------
// A byte request is taken while the engine is idle. Every 64th byte starts a block
// compression (load, 80 rounds through the single round unit, chaining add)
// with ready low. A request marked end of message pushes the padding one
// byte per cycle, into an extra block when the length spills over, with one
// or two compressions, then offers the five digest words H0..H4, one per
// accepted cycle, and starts over with the initial chaining values.
// The bit length wraps modulo 2^64.
module sha1_stream_hasher
    import sha1_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    sha1_in_if.sink     i_req,
    sha1_out_if.source  o_dig
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LOAD,
        S_ROUND,
        S_ADD,
        S_OUT
    } t_state;

    t_state                r_state, n_state;
    t_fill                 r_fill, n_fill;
    logic [LEN_BITS-1:0]   r_len, n_len;
    t_round                r_round, n_round;
    t_word_num             r_word, n_word;
    logic                  r_finishing, n_finishing;
    logic                  r_pad_mark, n_pad_mark;
    logic                  r_len_phase, n_len_phase;

    logic                  w_acc;
    logic                  w_len_now;
    logic [LEN_BITS-1:0]   w_len_sh;
    logic [7:0]            w_pad_byte;
    t_sched_ctl            w_sched;
    t_core_ctl             w_core;
    t_word                 w_w;
    t_chain                w_chain;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_acc       = i_req.valid && i_req.ready;

    assign w_len_now  = r_len_phase || (!r_pad_mark && (r_fill == LEN_POS));
    assign w_len_sh   = r_len >> (6'd56 - {r_fill[2:0], 3'b000});
    assign w_pad_byte = r_pad_mark ? PAD_MARK : (w_len_now ? w_len_sh[7:0] : 8'h00);

    always_comb begin
        w_sched.push  = (r_state == S_PAD) || (w_acc && i_req.byte_present);
        w_sched.shift = (r_state == S_ROUND);
        w_sched.data  = (r_state == S_PAD) ? w_pad_byte : i_req.data_byte;
        w_core.init   = (r_state == S_OUT) && o_dig.ready && (r_word == LAST_WRD);
        w_core.load   = (r_state == S_LOAD);
        w_core.step   = (r_state == S_ROUND);
        w_core.add    = (r_state == S_ADD);
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_len       = r_len;
        n_round     = r_round;
        n_word      = r_word;
        n_finishing = r_finishing;
        n_pad_mark  = r_pad_mark;
        n_len_phase = r_len_phase;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_req.byte_present) begin
                        n_fill = r_fill + 6'd1;
                        n_len  = r_len + 64'd8;
                        if (r_fill == LAST_POS) begin
                            n_state     = S_LOAD;
                            n_finishing = i_req.end_of_message;
                            n_pad_mark  = i_req.end_of_message;
                        end else if (i_req.end_of_message) begin
                            n_state     = S_PAD;
                            n_finishing = 1'b1;
                            n_pad_mark  = 1'b1;
                        end
                    end else if (i_req.end_of_message) begin
                        n_state     = S_PAD;
                        n_finishing = 1'b1;
                        n_pad_mark  = 1'b1;
                    end
                end
            end
            S_PAD: begin
                n_pad_mark = 1'b0;
                n_fill     = r_fill + 6'd1;
                if (w_len_now) begin
                    n_len_phase = 1'b1;
                end
                if (r_fill == LAST_POS) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_round = '0;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                n_round = r_round + 7'd1;
                if (r_round == LAST_RND) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                if (!r_finishing) begin
                    n_state = S_IDLE;
                end else if (r_len_phase) begin
                    n_word  = '0;
                    n_state = S_OUT;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_OUT: begin
                if (o_dig.ready) begin
                    if (r_word == LAST_WRD) begin
                        n_state     = S_IDLE;
                        n_fill      = '0;
                        n_len       = '0;
                        n_finishing = 1'b0;
                        n_pad_mark  = 1'b0;
                        n_len_phase = 1'b0;
                    end else begin
                        n_word = r_word + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_len       <= '0;
            r_round     <= '0;
            r_word      <= '0;
            r_finishing <= 1'b0;
            r_pad_mark  <= 1'b0;
            r_len_phase <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_len       <= n_len;
            r_round     <= n_round;
            r_word      <= n_word;
            r_finishing <= n_finishing;
            r_pad_mark  <= n_pad_mark;
            r_len_phase <= n_len_phase;
        end
    end

    sha1_sched u_sched (
        .i_clk (i_clk),
        .i_ctl (w_sched),
        .o_w   (w_w)
    );

    sha1_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_core),
        .i_round (r_round),
        .i_w     (w_w),
        .o_chain (w_chain)
    );

    assign o_dig.valid       = (r_state == S_OUT);
    assign o_dig.digest_word = w_chain[r_word];
    assign o_dig.word_number = r_word;
    assign o_dig.last_word   = (r_word == LAST_WRD);

endmodule
